FILE: design/yuv_test_pattern_pixel_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the test-pattern pixel core
// Implication and next-cycle implication checks on the rising clock edge.
// ----------------------------------------------------------------------------
`ifndef YUV_TEST_PATTERN_PIXEL_CORE_DEFINES_SVH
`define YUV_TEST_PATTERN_PIXEL_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication
`define YTP_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ytp: same-cycle property violated");
// Next-cycle implication
`define YTP_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ytp: next-cycle property violated");
`else
`define YTP_ASSERT_IMP(name, clk, rst, ante, cons)
`define YTP_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

FILE: design/ytp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ytp_pkg
// Shared types, constants and helper functions of the test-pattern core.
// ----------------------------------------------------------------------------
package ytp_pkg;

   localparam int MaxSide        = 4096;
   localparam int MaxDevices     = 1000;
   localparam int SideW          = $clog2(MaxSide) + 1;
   localparam int RemW           = $clog2(MaxSide);
   localparam int DevW           = 10;
   localparam int PhaseW         = 32;
   localparam int PixW           = 12;
   localparam int NumW           = 36;
   localparam int QuoW           = 7;
   localparam int StepsPerStage  = 4;
   localparam int DivStages      = NumW / StepsPerStage;
   localparam int LastStage      = DivStages - 1;

   localparam logic [SideW-1:0] HeightReset = SideW'(480);
   localparam logic [SideW-1:0] WidthReset  = SideW'(640);
   localparam logic [SideW-1:0] SideMin     = SideW'(2);
   localparam logic [SideW-1:0] SideMax     = SideW'(MaxSide);

   typedef enum logic {
      CsrFrameHeight = 1'b0,
      CsrFrameWidth  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [DevW-1:0]   device_index;
      logic [PhaseW-1:0] frame_phase;
      logic [PixW-1:0]   pixel_row;
      logic [PixW-1:0]   pixel_col;
   } req_word_type;

   typedef struct packed {
      logic [7:0] luma;
      logic [7:0] chroma_u;
      logic [7:0] chroma_v;
      logic       in_frame;
   } rsp_word_type;

   typedef struct packed {
      logic [PixW-1:0] row;
      logic            in_bounds;
      logic            stripe;
      logic [5:0]      hue_quarter;
   } side_type;

   typedef struct packed {
      logic [NumW-1:0] num;
      logic [RemW-1:0] rem;
   } lane_type;

   typedef struct packed {
      lane_type        bar_lane;
      lane_type        grad_lane;
      logic [QuoW-1:0] quo;
      side_type        side;
   } div_word_type;

   // Even, clamped frame side.
   function automatic logic [SideW-1:0] eff_side(logic [SideW-1:0] v);
      logic [SideW-1:0] e;
      e = {v[SideW-1:1], 1'b0};
      if (e < SideMin) e = SideMin;
      if (e > SideMax) e = SideMax;
      return e;
   endfunction

   // One restoring step: {quotient bit, next remainder}.
   function automatic logic [RemW:0] div_step(logic [RemW-1:0] rem, logic b,
                                              logic [SideW-1:0] h);
      logic [SideW-1:0] t;
      logic [SideW-1:0] diff;
      t    = {rem, b};
      diff = t - h;
      if (t >= h) return {1'b1, diff[RemW-1:0]};
      return {1'b0, t[RemW-1:0]};
   endfunction

endpackage

FILE: design/yuv_test_pattern_pixel_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv_test_pattern_pixel_core
// Test-pattern pixel generator: gradient luma, moving bar, stripes, chroma.
// ----------------------------------------------------------------------------
// Stages from request word to response word: 1 entry stage, 9 divider
//   stages of 4 restoring steps each, 1 output stage.
// Throughput: one word per cycle unless rsp_ready stalls; the divider bounds latency.
// Reset (synchronous, active high): empties all stages and loads frame
//   height 480 and frame width 640.
// ----------------------------------------------------------------------------
module yuv_test_pattern_pixel_core (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  ytp_pkg::req_word_type          req_word,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output ytp_pkg::rsp_word_type          rsp_word,
   // register write port
   input  logic                           csr_we,
   input  ytp_pkg::csr_index_type         csr_index,
   input  logic [ytp_pkg::SideW-1:0]      csr_wdata
);
   import ytp_pkg::*;

   // Frame sides are held already made even and clamped, so no stage
   // downstream has to repeat that work.
   logic [SideW-1:0] height_ff;
   logic [SideW-1:0] width_ff;

   logic             prep_valid;
   logic             prep_ready;
   div_word_type     prep_word;
   logic             div_valid;
   logic             div_ready;
   div_word_type     div_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= HeightReset;
         width_ff  <= WidthReset;
      end else if (csr_we) begin
         unique case (csr_index)
            CsrFrameHeight: height_ff <= eff_side(csr_wdata);
            CsrFrameWidth:  width_ff  <= eff_side(csr_wdata);
         endcase
      end
   end

   // Entry stage: saturate the device number, build the bar dividend
   // (phase*6 + device*13) and the gradient dividend (row*120), and settle
   // everything that does not need the height divide: hue, stripes, frame.
   ytp_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .h_side    (height_ff),
      .w_side    (width_ff),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_word   (req_word),
      .out_valid (prep_valid),
      .out_ready (prep_ready),
      .out_word  (prep_word)
   );

   // Divider: both dividends walk through the same stages, the bar lane
   // keeping its remainder and the gradient lane its quotient.
   ytp_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .h_side    (height_ff),
      .in_valid  (prep_valid),
      .in_ready  (prep_ready),
      .in_word   (prep_word),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_word  (div_word)
   );

   // Output stage: pick stripe, bar or gradient luma and hold the result
   // word until the consumer takes it; upstream stages keep filling.
   ytp_finish u_finish (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_ready  (div_ready),
      .in_word   (div_word),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_word  (rsp_word)
   );

endmodule

FILE: design/ytp_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ytp_prep
// Entry stage: saturate the device, form both dividends, hue, stripe, frame.
// ----------------------------------------------------------------------------
module ytp_prep (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [ytp_pkg::SideW-1:0]  h_side,
   input  logic [ytp_pkg::SideW-1:0]  w_side,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  ytp_pkg::req_word_type      in_word,
   output logic                       out_valid,
   input  logic                       out_ready,
   output ytp_pkg::div_word_type      out_word
);
   import ytp_pkg::*;

   localparam logic [DevW-1:0] DevMax = DevW'(MaxDevices - 1);

   logic               valid_ff;
   div_word_type       word_ff;
   div_word_type       word_in;
   logic               load;
   logic [DevW-1:0]    dev;
   logic [15:0]        hue_prod;
   logic [8:0]         hue_fold;
   logic [7:0]         hue;
   logic [DevW-1:0]    dev_inc;
   logic [23:0]        tenth_prod;
   logic [6:0]         tenth;
   logic [DevW-1:0]    count_full;
   logic [3:0]         count;
   logic [6:0]         stripe_cols;

   assign load     = !valid_ff || out_ready;
   assign in_ready = load;

   always_comb begin
      dev = (in_word.device_index >= DevW'(MaxDevices)) ? DevMax : in_word.device_index;

      // hue = dev*37 mod 255, by folding the two bytes (256 is 1 mod 255)
      hue_prod = 16'({dev, 5'b0}) + 16'({dev, 2'b0}) + 16'(dev);
      hue_fold = 9'(hue_prod[15:8]) + 9'(hue_prod[7:0]);
      hue      = (hue_fold >= 9'd255) ? 8'(hue_fold - 9'd255) : hue_fold[7:0];

      // stripe count = (dev+1) mod 10 via reciprocal 6554/65536
      dev_inc     = dev + DevW'(1);
      tenth_prod  = 24'(dev_inc) * 24'd6554;
      tenth       = tenth_prod[22:16];
      count_full  = dev_inc - DevW'({tenth, 3'b0}) - DevW'({tenth, 1'b0});
      count       = count_full[3:0];
      stripe_cols = 7'({count, 3'b0}) + 7'({count, 2'b0});

      word_in.bar_lane.num  = NumW'({in_word.frame_phase, 2'b0})
                            + NumW'({in_word.frame_phase, 1'b0})
                            + NumW'({dev, 3'b0}) + NumW'({dev, 2'b0}) + NumW'(dev);
      word_in.bar_lane.rem  = '0;
      word_in.grad_lane.num = NumW'({in_word.pixel_row, 7'b0})
                            - NumW'({in_word.pixel_row, 3'b0});
      word_in.grad_lane.rem = '0;
      word_in.quo           = '0;
      word_in.side.row      = in_word.pixel_row;
      word_in.side.in_bounds = (SideW'(in_word.pixel_row) < h_side)
                             && (SideW'(in_word.pixel_col) < w_side);
      word_in.side.stripe   = (in_word.pixel_row > PixW'(40))
                            && (in_word.pixel_row < PixW'(90))
                            && (in_word.pixel_col < PixW'(stripe_cols));
      word_in.side.hue_quarter = hue[7:2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

FILE: design/ytp_divider.sv
`timescale 1ns / 1ps
`include "yuv_test_pattern_pixel_core_defines.svh"
// ----------------------------------------------------------------------------
// ytp_divider
// Pipelined restoring divider: bar remainder and gradient quotient by height.
// ----------------------------------------------------------------------------
module ytp_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [ytp_pkg::SideW-1:0]  h_side,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  ytp_pkg::div_word_type      in_word,
   output logic                       out_valid,
   input  logic                       out_ready,
   output ytp_pkg::div_word_type      out_word
);
   import ytp_pkg::*;

   logic         valid_ff [DivStages];
   div_word_type word_ff  [DivStages];
   logic         valid_up [DivStages];
   div_word_type word_up  [DivStages];
   div_word_type word_in  [DivStages];
   logic         load     [DivStages];
   logic         ready_dn [DivStages];

   // Advance both lanes by StepsPerStage (4) dividend bits.
   function automatic div_word_type div_stage(div_word_type w, logic [SideW-1:0] h);
      div_word_type r;
      logic [RemW:0] sb;
      logic [RemW:0] sg;
      r = w;
      for (int i = 0; i < StepsPerStage; i++) begin
         sb = div_step(r.bar_lane.rem, r.bar_lane.num[NumW-1], h);
         sg = div_step(r.grad_lane.rem, r.grad_lane.num[NumW-1], h);
         r.bar_lane.num  = {r.bar_lane.num[NumW-2:0], 1'b0};
         r.bar_lane.rem  = sb[RemW-1:0];
         r.grad_lane.num = {r.grad_lane.num[NumW-2:0], 1'b0};
         r.grad_lane.rem = sg[RemW-1:0];
         r.quo           = {r.quo[QuoW-2:0], sg[RemW]};
      end
      return r;
   endfunction

   for (genvar s = 0; s < DivStages; s++) begin : g_stage
      if (s == 0) begin : g_head
         assign valid_up[s] = in_valid;
         assign word_up[s]  = in_word;
      end else begin : g_body
         assign valid_up[s] = valid_ff[s-1];
         assign word_up[s]  = word_ff[s-1];
      end

      if (s == LastStage) begin : g_tail
         assign ready_dn[s] = out_ready;
      end else begin : g_mid
         assign ready_dn[s] = load[s+1];
      end

      assign load[s]    = !valid_ff[s] || ready_dn[s];
      assign word_in[s] = div_stage(word_up[s], h_side);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (load[s]) begin
            valid_ff[s] <= valid_up[s];
         end
      end

      always_ff @(posedge clock) begin
         if (load[s]) begin
            word_ff[s] <= word_in[s];
         end
      end
   end

   assign in_ready  = load[0];
   assign out_valid = valid_ff[LastStage];
   assign out_word  = word_ff[LastStage];

   `YTP_ASSERT_IMP(a_bar_num_drained, clock, reset, valid_ff[LastStage], word_ff[LastStage].bar_lane.num == '0)
   `YTP_ASSERT_IMP(a_grad_num_drained, clock, reset, valid_ff[LastStage], word_ff[LastStage].grad_lane.num == '0)
   `YTP_ASSERT_NEXT(a_entry_fill, clock, reset, in_valid && load[0], valid_ff[0])

endmodule

FILE: design/ytp_finish.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ytp_finish
// Output stage: bar hit test, luma selection, chroma, result register.
// ----------------------------------------------------------------------------
module ytp_finish (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  ytp_pkg::div_word_type  in_word,
   output logic                   out_valid,
   input  logic                   out_ready,
   output ytp_pkg::rsp_word_type  out_word
);
   import ytp_pkg::*;

   logic              valid_ff;
   rsp_word_type      word_ff;
   rsp_word_type      word_in;
   logic              load;
   logic [SideW-1:0]  bar_end;
   logic              bar_hit;

   assign load     = !valid_ff || out_ready;
   assign in_ready = load;

   always_comb begin
      bar_end = SideW'(in_word.bar_lane.rem) + SideW'(24);
      bar_hit = (in_word.side.row >= in_word.bar_lane.rem)
              && (SideW'(in_word.side.row) < bar_end);

      priority if (!in_word.side.in_bounds) begin
         word_in.luma = 8'd0;
      end else if (in_word.side.stripe) begin
         word_in.luma = 8'd200;
      end else if (bar_hit) begin
         word_in.luma = 8'd235;
      end else begin
         word_in.luma = 8'd40 + 8'(in_word.quo);
      end
      word_in.chroma_u = 8'd128 - 8'(in_word.side.hue_quarter);
      word_in.chroma_v = 8'd128 + 8'(in_word.side.hue_quarter);
      word_in.in_frame = in_word.side.in_bounds;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives pixel requests into the test-pattern core, predicts each response
// word (gradient, moving bar, stripes, device chroma, in-frame flag) and
// compares it field by field, across several frame sizes written between
// bursts, with random gaps and backpressure on both channels.
// ----------------------------------------------------------------------------
module testbench;
   import ytp_pkg::*;

   // Pipe depth of the core; settle a bit longer than that.
   localparam int PipeDepth  = 11;
   localparam int SettleWait = PipeDepth + 6;
   localparam int StallLimit = 2000;
   localparam int IdlePct    = 14;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_word_type          req_word;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_word_type          rsp_word;
   logic                  csr_we;
   csr_index_type         csr_index;
   logic [SideW-1:0]      csr_wdata;

   // Shadow copies of the size registers, raw as written.
   logic [SideW-1:0]      height_shadow;
   logic [SideW-1:0]      width_shadow;

   rsp_word_type          expected_pixels[$];
   int                    error_count = 0;
   int                    quiet_cycles = 0;
   bit                    steady_stream;

   yuv_test_pattern_pixel_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Pattern prediction
   // ------------------------------------------------------------------------

   // Drop bit 0, then clamp into 2..MaxSide.
   function automatic longint unsigned clamp_side(logic [SideW-1:0] raw);
      longint unsigned even;
      even = longint'(raw) & ~64'd1;
      if (even < 2) even = 2;
      if (even > MaxSide) even = MaxSide;
      return even;
   endfunction

   function automatic rsp_word_type predict_pixel(req_word_type px);
      longint unsigned h, w, dev, row, col, hue, bar_top;
      rsp_word_type    r;
      h   = clamp_side(height_shadow);
      w   = clamp_side(width_shadow);
      dev = px.device_index;
      if (dev >= MaxDevices) dev = MaxDevices - 1;
      row = px.pixel_row;
      col = px.pixel_col;
      hue = (dev * 37) % 255;
      r.chroma_u = 8'(128 - hue / 4);
      r.chroma_v = 8'(128 + hue / 4);
      r.in_frame = (row < h) && (col < w);
      r.luma     = 8'd0;
      if (r.in_frame) begin
         // Full 64-bit product, so a huge phase cannot wrap.
         bar_top = (64'(px.frame_phase) * 6 + dev * 13) % h;
         if (row >= bar_top && row < bar_top + 24)
            r.luma = 8'd235;
         else
            r.luma = 8'(40 + (row * 120) / h);
         // Stripe band wins over both bar and gradient.
         if (row > 40 && row < 90 && col / 12 < 10 && col / 12 < (dev + 1) % 10)
            r.luma = 8'd200;
      end
      return r;
   endfunction

   function automatic req_word_type pixel(int dev, logic [31:0] phase, int row, int col);
      req_word_type px;
      px.device_index = DevW'(dev);
      px.frame_phase  = phase;
      px.pixel_row    = PixW'(row);
      px.pixel_col    = PixW'(col);
      return px;
   endfunction

   // Random request, biased toward the interesting parts of the frame.
   function automatic req_word_type random_pixel();
      req_word_type    px;
      longint unsigned h, w, dev, bar_top;
      int              pick, row;
      h = clamp_side(height_shadow);
      w = clamp_side(width_shadow);
      px.device_index = DevW'($urandom_range(0, 1023));
      px.frame_phase  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 200) : $urandom;
      px.pixel_row    = PixW'($urandom);
      px.pixel_col    = PixW'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         // anywhere inside the frame
         px.pixel_row = PixW'($urandom_range(0, int'(h) - 1));
         px.pixel_col = PixW'($urandom_range(0, int'(w) - 1));
      end else if (pick < 70) begin
         // stripe band and its edges
         px.pixel_row = PixW'($urandom_range(38, 92));
         px.pixel_col = PixW'($urandom_range(0, 130));
      end else if (pick < 88) begin
         // around the bar's top and bottom edges
         dev = px.device_index;
         if (dev >= MaxDevices) dev = MaxDevices - 1;
         bar_top = (64'(px.frame_phase) * 6 + dev * 13) % h;
         row = int'(bar_top) + $urandom_range(0, 27) - 2;
         if (row < 0) row = 0;
         if (row > 4095) row = 4095;
         px.pixel_row = PixW'(row);
         px.pixel_col = PixW'($urandom_range(0, int'(w) - 1));
      end
      // else: leave the fully random row and column
      return px;
   endfunction

   // ------------------------------------------------------------------------
   // Shared helpers
   // ------------------------------------------------------------------------

   task automatic report_mismatch(string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      error_count++;
   endtask

   // Offer one word; hold it until accepted, then queue its prediction.
   task automatic send_pixel(req_word_type px);
      if (!steady_stream) begin
         while ($urandom_range(0, 99) < IdlePct) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_word  <= px;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_pixels.push_back(predict_pixel(px));
   endtask

   // Drop valid and wait until every response is back, then wait out the settle time.
   task automatic wait_pattern_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SettleWait) @(posedge clock);
   endtask

   // Write both size registers back to back; the core must be idle.
   task automatic write_frame_size(logic [SideW-1:0] h, logic [SideW-1:0] w);
      csr_we    <= 1'b1;
      csr_index <= CsrFrameHeight;
      csr_wdata <= h;
      @(posedge clock);
      height_shadow = h;
      csr_index <= CsrFrameWidth;
      csr_wdata <= w;
      @(posedge clock);
      width_shadow = w;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_random_burst(int count);
      for (int n = 0; n < count; n++) send_pixel(random_pixel());
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Corners at the reset size (480 x 640).
   task automatic test_directed_pattern();
      send_pixel(pixel(0, 0, 0, 0));                    // bar starts at row 0
      send_pixel(pixel(999, 32'hFFFF_FFFF, 4095, 4095)); // far outside, max phase
      send_pixel(pixel(1000, 7, 200, 300));             // index saturates
      send_pixel(pixel(1023, 32'hFFFF_FFFF, 100, 100)); // all-ones index
      send_pixel(pixel(5, 3, 479, 639));                // last pixel inside
      send_pixel(pixel(5, 3, 480, 0));                  // one row past the bottom
      send_pixel(pixel(5, 3, 0, 640));                  // one column past the edge
      // bar at rows 60..83: check both edges, away from the stripes
      send_pixel(pixel(0, 10, 59, 300));
      send_pixel(pixel(0, 10, 60, 300));
      send_pixel(pixel(0, 10, 83, 300));
      send_pixel(pixel(0, 10, 84, 300));
      // bar starting at row 470 is cut off at the bottom, no wrap to the top
      send_pixel(pixel(2, 74, 469, 300));
      send_pixel(pixel(2, 74, 479, 300));
      send_pixel(pixel(2, 74, 5, 300));
      // stripes: nine stripes for index 8, none for index 9
      send_pixel(pixel(8, 500, 40, 0));
      send_pixel(pixel(8, 500, 41, 0));
      send_pixel(pixel(8, 500, 89, 0));
      send_pixel(pixel(8, 500, 90, 0));
      send_pixel(pixel(8, 500, 60, 107));
      send_pixel(pixel(8, 500, 60, 108));
      send_pixel(pixel(9, 500, 50, 0));
      send_pixel(pixel(998, 500, 60, 50));
      send_pixel(pixel(1015, 1, 45, 11));               // saturated index stripes
      wait_pattern_drained();
   endtask

   // Odd, tiny, huge and out-of-range sizes.
   task automatic test_frame_sizes();
      logic [SideW-1:0] heights[6] = '{13'd0, 13'd2, 13'd3, 13'd4096, 13'd4097, 13'd8190};
      logic [SideW-1:0] widths[6]  = '{13'd1, 13'd2, 13'd8191, 13'd4096, 13'd2, 13'd4095};
      for (int k = 0; k < 6; k++) begin
         write_frame_size(heights[k], widths[k]);
         send_random_burst(20);
         wait_pattern_drained();
      end
   endtask

   // Bulk random traffic over several sizes, with one full pause mid-burst.
   task automatic test_random_pixels();
      logic [SideW-1:0] h, w;
      for (int k = 0; k < 6; k++) begin
         case (k)
            0:       begin h = HeightReset; w = WidthReset; end
            1:       begin h = 13'd64;      w = 13'd200;    end
            2:       begin h = 13'd8191;    w = 13'd8191;   end
            default: begin
               h = SideW'($urandom_range(0, 8191));
               w = SideW'($urandom_range(0, 8191));
            end
         endcase
         write_frame_size(h, w);
         send_random_burst(65);
         // sender holds off until the core is empty, then resumes
         if (k == 3) wait_pattern_drained();
         send_random_burst(65);
         wait_pattern_drained();
      end
   endtask

   // Back-to-back words with the sink always ready.
   task automatic test_steady_stream();
      write_frame_size(13'd96, 13'd128);
      steady_stream = 1'b1;
      send_random_burst(150);
      wait_pattern_drained();
      steady_stream = 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Response checker: compare each accepted word with the oldest prediction
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : check_rsp
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            report_mismatch("response word with nothing pending");
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_word.luma != want.luma)
               report_mismatch($sformatf("luma exp %0d got %0d", want.luma, rsp_word.luma));
            if (rsp_word.chroma_u != want.chroma_u)
               report_mismatch($sformatf("chroma_u exp %0d got %0d",
                                         want.chroma_u, rsp_word.chroma_u));
            if (rsp_word.chroma_v != want.chroma_v)
               report_mismatch($sformatf("chroma_v exp %0d got %0d",
                                         want.chroma_v, rsp_word.chroma_v));
            if (rsp_word.in_frame != want.in_frame)
               report_mismatch($sformatf("in_frame exp %0d got %0d",
                                         want.in_frame, rsp_word.in_frame));
         end
      end
      // stall the sink at random outside the steady stretch
      rsp_ready <= steady_stream || ($urandom_range(0, 99) >= IdlePct);
   end

   // ------------------------------------------------------------------------
   // Watchdog: end the run if no word moves on either channel for too long
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
         $display("testbench: errors");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_word      = '0;
      csr_we        = 1'b0;
      csr_index     = CsrFrameHeight;
      csr_wdata     = '0;
      height_shadow = HeightReset;
      width_shadow  = WidthReset;
      steady_stream = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_pattern();
      test_frame_sizes();
      test_random_pixels();
      test_steady_stream();

      // catch any stray word after the last expected one
      wait_pattern_drained();
      repeat (PipeDepth + 8) @(posedge clock);
      if (error_count == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule
